// File: hdl/lfu_pkg.sv
// Shared types and constants for the LFU cache directory.
// No dependencies; every other file of the block imports this package.
package lfu_pkg;

  localparam int KEY_W   = 64;
  localparam int COUNT_W = 32;
  localparam int TIME_W  = 48;
  localparam int CAP_W   = 7;

  localparam logic [CAP_W-1:0]   CAP_RESET = 7'd64;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Request command codes.
  localparam logic CMD_ACCESS = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  // One directory entry as stored in the entry memory.
  typedef struct packed {
    logic               valid;
    logic [KEY_W-1:0]   key;
    logic [COUNT_W-1:0] count;
    logic [TIME_W-1:0]  stamp;
  } entry_t;

  // Outcome of the shared compare unit.
  typedef struct packed {
    logic key_eq;   // keys are equal
    logic earlier;  // entry A is evicted ahead of entry B
    logic tie;      // equal count and equal time
  } cmp_t;

endpackage

// File: hdl/lfu_ifs.sv
// Handshake interfaces for the request, response and configuration channels.
// Depends on lfu_pkg for the field widths.
interface lfu_req_if import lfu_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              command;
  logic [KEY_W-1:0]  key;
  logic [TIME_W-1:0] request_time;

  modport source (output valid, command, key, request_time, input ready);
  modport sink   (input valid, command, key, request_time, output ready);
endinterface

interface lfu_rsp_if import lfu_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             hit;
  logic             evicted_valid;
  logic [KEY_W-1:0] victim_key;

  modport source (output valid, hit, evicted_valid, victim_key, input ready);
  modport sink   (input valid, hit, evicted_valid, victim_key, output ready);
endinterface

interface lfu_cfg_if import lfu_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CAP_W-1:0] capacity;

  modport source (output valid, capacity, input ready);
  modport sink   (input valid, capacity, output ready);
endinterface

// File: hdl/lfu_ram.sv
// Entry memory: one write port, one read port with registered read data.
// Depends on lfu_pkg for the entry layout.
module lfu_ram import lfu_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  entry_t                   wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output entry_t                   rd_data
);

  entry_t mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, registered: data appears in the cycle after the address.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hdl/lfu_cmp.sv
// Shared compare unit: key match and eviction order of two entries.
// Depends on lfu_pkg for widths and the result struct.
module lfu_cmp import lfu_pkg::*; (
  input  logic [KEY_W-1:0]   a_key,
  input  logic [COUNT_W-1:0] a_count,
  input  logic [TIME_W-1:0]  a_stamp,
  input  logic [KEY_W-1:0]   b_key,
  input  logic [COUNT_W-1:0] b_count,
  input  logic [TIME_W-1:0]  b_stamp,
  output cmp_t               result
);

  // Lower count goes first; equal counts fall back to the older time.
  always_comb begin
    result.key_eq = (a_key == b_key);
    result.tie    = (a_count == b_count) && (a_stamp == b_stamp);
    if (a_count != b_count) begin
      result.earlier = (a_count < b_count);
    end else begin
      result.earlier = (a_stamp < b_stamp);
    end
  end

endmodule

// File: hdl/lfu_replacement_lru_tiebreak.sv
// LFU cache directory with LRU tie-break.
// Requests arrive on req (command, key, request_time); one response per
// request leaves on rsp (hit, evicted_valid, victim_key). cfg writes the
// capacity register; it is always ready and must only be written while the
// block is idle.
// Each request is handled by a sequencer that scans all NUM_ENTRIES slots of
// the entry memory through its single read port, one slot per cycle, feeding
// one shared compare unit that finds the key and the eviction candidate.
// The response becomes valid once the scan with its read latency, an update
// state and a done state that loads the response register are through; the
// sequencer then returns to idle and only there accepts the next request, so
// a new request is never taken before the previous one is finished.
// req.ready is high only while the block idles.
// After reset a clearing pass marks every slot empty, one slot at a time;
// no request is accepted during it, configuration writes are.
// The response register holds while rsp.ready is low; a finished request
// then waits in the sequencer and no new request is taken.
// Depends on lfu_pkg, lfu_ifs, lfu_ram and lfu_cmp.
module lfu_replacement_lru_tiebreak import lfu_pkg::*; #(
  parameter int NUM_ENTRIES = 64
) (
  input  logic       clk,
  input  logic       rst,
  lfu_cfg_if.sink    cfg,
  lfu_req_if.sink    req,
  lfu_rsp_if.source  rsp
);

  localparam int IW   = $clog2(NUM_ENTRIES);
  localparam int SW   = IW + 1;
  localparam int RCW  = $clog2(NUM_ENTRIES + 1);
  localparam int CMPW = (RCW > CAP_W) ? RCW : CAP_W;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_DONE
  } state_t;

  state_t             state;
  logic [CAP_W-1:0]   capacity;
  logic [RCW-1:0]     resident;
  logic [SW-1:0]      scan_idx;
  logic               pend_valid;
  logic [IW-1:0]      pend_idx;

  // Latched request.
  logic               cmd_r;
  logic [KEY_W-1:0]   key_r;
  logic [TIME_W-1:0]  time_r;

  // Scan results.
  logic               hit_found;
  logic [IW-1:0]      hit_slot;
  logic [COUNT_W-1:0] hit_count;
  logic               free_found;
  logic [IW-1:0]      free_slot;
  logic               victim_found;
  logic [IW-1:0]      victim_slot;
  logic [COUNT_W-1:0] vc;
  logic [TIME_W-1:0]  vt;
  logic [KEY_W-1:0]   vkey;

  // Result waiting for the response register.
  logic               res_hit;
  logic               res_ev;
  logic [KEY_W-1:0]   res_key;

  // Response register.
  logic               rsp_valid;
  logic               out_hit;
  logic               out_ev;
  logic [KEY_W-1:0]   out_key;

  // Memory ports and compare result.
  logic               wr_en;
  logic [IW-1:0]      wr_addr;
  entry_t             wr_data;
  logic               rd_en;
  entry_t             rd_data;
  cmp_t               cmp;

  logic [CMPW-1:0]    eff_cap;
  logic               full;
  logic               issue;
  logic               take_victim;

  assign cfg.ready     = 1'b1;
  assign req.ready     = (state == ST_IDLE);
  assign rsp.valid     = rsp_valid;
  assign rsp.hit       = out_hit;
  assign rsp.evicted_valid = out_ev;
  assign rsp.victim_key    = out_key;

  // Capacity clamped to the range one to NUM_ENTRIES.
  always_comb begin
    eff_cap = CMPW'(capacity);
    if (capacity == '0) begin
      eff_cap = CMPW'(1);
    end
    if (eff_cap > CMPW'(NUM_ENTRIES)) begin
      eff_cap = CMPW'(NUM_ENTRIES);
    end
  end

  // A miss must evict when residency already reaches the capacity.
  assign full = (CMPW'(resident) >= eff_cap);

  // Scan read issue.
  assign issue = (state == ST_SCAN) && (scan_idx != SW'(NUM_ENTRIES));
  assign rd_en = issue;

  lfu_ram #(
    .DEPTH (NUM_ENTRIES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (scan_idx[IW-1:0]),
    .rd_data (rd_data)
  );

  lfu_cmp u_cmp (
    .a_key   (rd_data.key),
    .a_count (rd_data.count),
    .a_stamp (rd_data.stamp),
    .b_key   (key_r),
    .b_count (vc),
    .b_stamp (vt),
    .result  (cmp)
  );

  // Until a resident wins, the new key loses ties; afterwards only a strictly
  // earlier entry replaces the candidate, so the lowest slot wins ties.
  assign take_victim = victim_found ? cmp.earlier : (cmp.earlier || cmp.tie);

  // Memory write: clearing pass, or the single update of a request.
  always_comb begin
    wr_en         = 1'b0;
    wr_addr       = hit_slot;
    wr_data.valid = 1'b1;
    wr_data.key   = key_r;
    wr_data.count = COUNT_W'(1);
    wr_data.stamp = time_r;
    case (state)
      ST_CLEAR: begin
        wr_en         = 1'b1;
        wr_addr       = scan_idx[IW-1:0];
        wr_data.valid = 1'b0;
      end
      ST_UPDATE: begin
        if (cmd_r == CMD_REMOVE) begin
          wr_en         = hit_found;
          wr_data.valid = 1'b0;
        end else if (hit_found) begin
          wr_en         = 1'b1;
          wr_data.count = (hit_count == COUNT_MAX) ? hit_count : hit_count + COUNT_W'(1);
        end else if (full) begin
          wr_en   = victim_found;
          wr_addr = victim_slot;
        end else begin
          wr_en   = 1'b1;
          wr_addr = free_slot;
        end
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // Sequencer, scan bookkeeping and response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      capacity   <= CAP_RESET;
      resident   <= '0;
      scan_idx   <= '0;
      pend_valid <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      if (cfg.valid) begin
        capacity <= cfg.capacity;
      end
      // The response leaves on a handshake unless a new one is loaded now.
      if (rsp_valid && rsp.ready && state != ST_DONE) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          scan_idx <= scan_idx + SW'(1);
          if (scan_idx == SW'(NUM_ENTRIES - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (req.valid) begin
            cmd_r        <= req.command;
            key_r        <= req.key;
            time_r       <= req.request_time;
            hit_found    <= 1'b0;
            free_found   <= 1'b0;
            victim_found <= 1'b0;
            vc           <= COUNT_W'(1);
            vt           <= req.request_time;
            scan_idx     <= '0;
            pend_valid   <= 1'b0;
            state        <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          pend_valid <= issue;
          pend_idx   <= scan_idx[IW-1:0];
          if (issue) begin
            scan_idx <= scan_idx + SW'(1);
          end
          // Evaluate the slot whose data has just arrived.
          if (pend_valid) begin
            if (rd_data.valid) begin
              if (cmp.key_eq && !hit_found) begin
                hit_found <= 1'b1;
                hit_slot  <= pend_idx;
                hit_count <= rd_data.count;
              end
              if (take_victim) begin
                victim_found <= 1'b1;
                victim_slot  <= pend_idx;
                vc           <= rd_data.count;
                vt           <= rd_data.stamp;
                vkey         <= rd_data.key;
              end
            end else if (!free_found) begin
              free_found <= 1'b1;
              free_slot  <= pend_idx;
            end
          end
          if (!issue && !pend_valid) begin
            state <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          res_hit <= hit_found;
          // Only a miss at full capacity reports an eviction.
          if (cmd_r == CMD_ACCESS && !hit_found && full) begin
            res_ev  <= 1'b1;
            res_key <= victim_found ? vkey : key_r;
          end else begin
            res_ev  <= 1'b0;
            res_key <= '0;
          end
          if (cmd_r == CMD_REMOVE) begin
            if (hit_found) begin
              resident <= resident - RCW'(1);
            end
          end else if (!hit_found && !full) begin
            resident <= resident + RCW'(1);
          end
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (!rsp_valid || rsp.ready) begin
            rsp_valid <= 1'b1;
            out_hit   <= res_hit;
            out_ev    <= res_ev;
            out_key   <= res_key;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  // A miss below capacity always finds an empty slot.
  a_free_on_insert: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPDATE && cmd_r == CMD_ACCESS && !hit_found && !full) |-> free_found)
    else $error("insert without a free slot");

  // A remove that hits never drives residency below zero.
  a_remove_resident: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPDATE && cmd_r == CMD_REMOVE && hit_found) |-> (resident != '0))
    else $error("remove hit with zero residency");

  // An accepted request starts a scan from slot zero.
  a_accept_scan: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> (state == ST_SCAN && scan_idx == '0))
    else $error("accepted request did not start a scan");

  // Residency never exceeds the number of slots.
  a_resident_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) |-> (CMPW'(resident) <= CMPW'(NUM_ENTRIES)))
    else $error("residency beyond the number of slots");
`endif

endmodule

// File: bench/lfu_checker.sv
`timescale 1ns / 100ps
// Response checker for the LFU cache directory: watches the cfg, req and rsp channels,
// keeps its own copy of the directory and compares every response with its prediction.
// Depends on lfu_pkg and the channel interfaces in lfu_ifs.
module lfu_checker import lfu_pkg::*; #(
  parameter int ENTRIES = 64
) (
  input  logic clk,
  input  logic rst,
  lfu_cfg_if   cfg,
  lfu_req_if   req,
  lfu_rsp_if   rsp,
  output int   err_count,
  output int   pending
);

  typedef struct packed {
    logic             hit;
    logic             evicted_valid;
    logic [KEY_W-1:0] victim_key;
  } outcome_t;

  // Shadow copy of the directory and the capacity register.
  logic               dir_valid [ENTRIES];
  logic [KEY_W-1:0]   dir_key   [ENTRIES];
  logic [COUNT_W-1:0] dir_count [ENTRIES];
  logic [TIME_W-1:0]  dir_stamp [ENTRIES];
  int                 resident;
  logic [CAP_W-1:0]   capacity;

  outcome_t outcome_q [$];
  int       errs;

  // True if entry A (count, time) is to be evicted ahead of entry B.
  function automatic logic evicts_first(input logic [COUNT_W-1:0] ca,
                                        input logic [TIME_W-1:0] ta,
                                        input logic [COUNT_W-1:0] cb,
                                        input logic [TIME_W-1:0] tb);
    if (ca != cb) return ca < cb;
    return ta < tb;
  endfunction

  // Applies one request to the shadow directory and returns the response it must cause.
  function automatic outcome_t predict_access(input logic cmd,
                                              input logic [KEY_W-1:0] key,
                                              input logic [TIME_W-1:0] now);
    outcome_t           res;
    int                 slot;
    int                 victim;
    int                 limit;
    logic [COUNT_W-1:0] vc;
    logic [TIME_W-1:0]  vt;
    logic               placed;
    res    = '0;
    slot   = -1;
    victim = -1;
    placed = 1'b0;
    for (int i = 0; i < ENTRIES; i++)
      if (slot < 0 && dir_valid[i] && dir_key[i] == key) slot = i;

    // A remove only drops a resident key.
    if (cmd == CMD_REMOVE) begin
      if (slot >= 0) begin
        res.hit         = 1'b1;
        dir_valid[slot] = 1'b0;
        if (resident > 0) resident--;
      end
      return res;
    end

    // A hit bumps the count, saturating, and refreshes the time.
    if (slot >= 0) begin
      res.hit = 1'b1;
      if (dir_count[slot] != COUNT_MAX) dir_count[slot]++;
      dir_stamp[slot] = now;
      return res;
    end

    // Out-of-range capacity values are clamped to 1 .. ENTRIES.
    limit = (capacity == 0) ? 1 : int'(capacity);
    if (limit > ENTRIES) limit = ENTRIES;

    // Full: the new key competes with every resident entry; exact ties favor evicting a resident.
    if (resident + 1 > limit) begin
      vc = 1;
      vt = now;
      for (int i = 0; i < ENTRIES; i++) begin
        if (dir_valid[i]) begin
          if (victim < 0) begin
            if (!evicts_first(vc, vt, dir_count[i], dir_stamp[i])) begin
              victim = i;
              vc     = dir_count[i];
              vt     = dir_stamp[i];
            end
          end else if (evicts_first(dir_count[i], dir_stamp[i], vc, vt)) begin
            victim = i;
            vc     = dir_count[i];
            vt     = dir_stamp[i];
          end
        end
      end
      res.evicted_valid = 1'b1;
      if (victim < 0) begin
        res.victim_key = key;
      end else begin
        res.victim_key    = dir_key[victim];
        dir_key[victim]   = key;
        dir_count[victim] = 1;
        dir_stamp[victim] = now;
      end
      return res;
    end

    // Room left: the key goes into the lowest free slot.
    for (int i = 0; i < ENTRIES; i++) begin
      if (!placed && !dir_valid[i]) begin
        dir_valid[i] = 1'b1;
        dir_key[i]   = key;
        dir_count[i] = 1;
        dir_stamp[i] = now;
        resident++;
        placed = 1'b1;
      end
    end
    return res;
  endfunction

  task automatic flag_field(input string field, input logic [KEY_W-1:0] want,
                            input logic [KEY_W-1:0] got);
    $display("%0t: rsp %s mismatch, expected %h actual %h", $time, field, want, got);
    errs++;
  endtask

  // Responses are checked before the request of the same edge is predicted.
  always @(posedge clk) begin : watch
    outcome_t want;
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) dir_valid[i] = 1'b0;
      resident = 0;
      capacity = CAP_RESET;
      outcome_q.delete();
      errs      = 0;
      err_count <= 0;
      pending   <= 0;
    end else begin
      if (cfg.valid && cfg.ready) capacity = cfg.capacity;
      if (rsp.valid && rsp.ready) begin
        if (outcome_q.size() == 0) begin
          $display("%0t: rsp with no request outstanding, actual hit %b ev %b key %h",
                   $time, rsp.hit, rsp.evicted_valid, rsp.victim_key);
          errs++;
        end else begin
          want = outcome_q.pop_front();
          if (rsp.hit !== want.hit) flag_field("hit", KEY_W'(want.hit), KEY_W'(rsp.hit));
          if (rsp.evicted_valid !== want.evicted_valid)
            flag_field("evicted_valid", KEY_W'(want.evicted_valid),
                       KEY_W'(rsp.evicted_valid));
          if (rsp.victim_key !== want.victim_key)
            flag_field("victim_key", want.victim_key, rsp.victim_key);
        end
      end
      if (req.valid && req.ready)
        outcome_q.push_back(predict_access(req.command, req.key, req.request_time));
      pending   <= outcome_q.size();
      err_count <= errs;
    end
  end

endmodule

// File: bench/tb_lfu_replacement_lru_tiebreak.sv
`timescale 1ns / 100ps
// Top of the LFU cache directory testbench: clock, reset, request stimulus, response
// back-pressure and the verdict. Depends on lfu_pkg, lfu_ifs, the block and lfu_checker.
module tb_lfu_replacement_lru_tiebreak;
  import lfu_pkg::*;

  localparam int N_ENTRIES = 64;
  localparam int PHASES    = 8;
  localparam int PHASE_LEN = 250;

  localparam logic [KEY_W-1:0] KEY_A = 64'h0123_4567_89ab_cdef;
  localparam logic [KEY_W-1:0] KEY_B = 64'hfedc_ba98_7654_3210;
  localparam logic [KEY_W-1:0] KEY_C = 64'h8000_0000_0000_0001;
  localparam logic [KEY_W-1:0] KEY_D = 64'h5555_aaaa_5555_aaaa;
  localparam logic [KEY_W-1:0] KEY_E = 64'h0000_0001_0000_0000;
  localparam logic [KEY_W-1:0] KEY_F = 64'h7fff_ffff_ffff_fffe;
  localparam logic [KEY_W-1:0] KEY_G = 64'h1357_9bdf_2468_ace0;

  logic clk;
  logic rst;
  int   err_count;
  int   pending;
  int   send_idle = 0;
  int   rsp_stall = 0;

  logic [KEY_W-1:0]  key_pool [80];
  int                pool_n;
  logic [TIME_W-1:0] clock_stamp;
  logic [CAP_W-1:0]  phase_cap [PHASES];

  lfu_cfg_if cfg_ch ();
  lfu_req_if req_ch ();
  lfu_rsp_if rsp_ch ();

  lfu_replacement_lru_tiebreak #(.NUM_ENTRIES(N_ENTRIES)) u_dut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_ch),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  lfu_checker #(.ENTRIES(N_ENTRIES)) u_checker (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg_ch),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .err_count (err_count),
    .pending   (pending)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Response back-pressure, redrawn every cycle.
  always @(posedge clk) begin
    rsp_ch.ready <= ($urandom_range(99) >= rsp_stall);
  end

  // Hard stop in case the block hangs.
  initial begin
    #3_000_000;
    $display("tb_lfu_replacement_lru_tiebreak: done, errors");
    $finish;
  end

  // Offers one request, sometimes after a gap, and returns at the edge it is taken.
  task automatic send_req(input logic cmd, input logic [KEY_W-1:0] key,
                          input logic [TIME_W-1:0] stamp);
    if ($urandom_range(99) < send_idle) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 80)) @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.command      <= cmd;
    req_ch.key          <= key;
    req_ch.request_time <= stamp;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // Withdraws the request channel and waits until every response is back.
  task automatic drain();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] value);
    drain();
    cfg_ch.valid    <= 1'b1;
    cfg_ch.capacity <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  // Mostly keys from a small pool so hits and evictions are common; the clock may wrap.
  task automatic random_item();
    logic [KEY_W-1:0]  key;
    logic [TIME_W-1:0] stamp;
    logic              cmd;
    if ($urandom_range(99) < 8) key = {$urandom, $urandom};
    else key = key_pool[$urandom_range(pool_n - 1)];
    clock_stamp += TIME_W'($urandom_range(3));
    if ($urandom_range(99) < 5) stamp = TIME_W'({$urandom, $urandom});
    else stamp = clock_stamp;
    cmd = ($urandom_range(99) < 20) ? CMD_REMOVE : CMD_ACCESS;
    send_req(cmd, key, stamp);
  endtask

  initial begin : stimulus
    int limit;
    req_ch.valid        = 1'b0;
    req_ch.command      = CMD_ACCESS;
    req_ch.key          = '0;
    req_ch.request_time = '0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.capacity     = CAP_RESET;
    rst                 = 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: extreme keys and times, hits, the new key itself being evicted, an exact tie.
    write_capacity(7'd2);
    send_req(CMD_ACCESS, '0, 48'd5);
    send_req(CMD_ACCESS, '1, '1);
    send_req(CMD_ACCESS, '0, 48'd6);
    send_req(CMD_ACCESS, KEY_A, '0);
    send_req(CMD_ACCESS, KEY_B, '1);
    // Removes of absent and present keys.
    send_req(CMD_REMOVE, KEY_C, 48'd1);
    send_req(CMD_REMOVE, '0, 48'd2);
    send_req(CMD_REMOVE, '0, 48'd3);
    send_req(CMD_ACCESS, KEY_B, 48'd7);
    // A capacity of zero behaves as one.
    write_capacity(7'd0);
    send_req(CMD_ACCESS, KEY_D, 48'd8);
    send_req(CMD_ACCESS, KEY_B, 48'd9);
    // Lowering the capacity below residency evicts nothing until the next miss.
    write_capacity(7'd3);
    send_req(CMD_ACCESS, KEY_E, 48'd10);
    send_req(CMD_ACCESS, KEY_F, 48'd10);
    write_capacity(7'd1);
    send_req(CMD_ACCESS, KEY_G, 48'd11);
    send_req(CMD_ACCESS, KEY_E, 48'd12);
    send_req(CMD_REMOVE, KEY_E, 48'd13);
    send_req(CMD_ACCESS, KEY_A, 48'd14);
    // Count saturation needs four billion hits on one key and is out of reach here.
    write_capacity(7'd127);
    send_req(CMD_ACCESS, KEY_C, 48'd15);

    // Random phases, each with its own capacity and idling pattern.
    phase_cap = '{7'd1, 7'd64, 7'd5, 7'd127, 7'd2, 7'd65, 7'd12, 7'd40};
    phase_cap[PHASES-1] = CAP_W'($urandom_range(1, 63));
    for (int p = 0; p < PHASES; p++) begin
      write_capacity(phase_cap[p]);
      case (p % 4)
        0: begin send_idle = 0;  rsp_stall = 0;  end
        1: begin send_idle = 68; rsp_stall = 0;  end
        2: begin send_idle = 0;  rsp_stall = 68; end
        default: begin send_idle = 24; rsp_stall = 24; end
      endcase
      limit = (phase_cap[p] == 0) ? 1 : int'(phase_cap[p]);
      if (limit > N_ENTRIES) limit = N_ENTRIES;
      pool_n = limit + $urandom_range(1, 8);
      for (int i = 0; i < pool_n; i++) key_pool[i] = {$urandom, $urandom};
      key_pool[0] = '0;
      key_pool[1] = '1;
      clock_stamp = TIME_W'({$urandom, $urandom});
      repeat (PHASE_LEN) random_item();
    end

    drain();
    rsp_stall = 0;
    repeat (2 * N_ENTRIES + 8) @(posedge clk);
    if (err_count == 0) begin
      $display("tb_lfu_replacement_lru_tiebreak: done, clean");
    end else begin
      $display("tb_lfu_replacement_lru_tiebreak: done, errors");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/lfu_pkg.sv
hdl/lfu_ifs.sv
hdl/lfu_ram.sv
hdl/lfu_cmp.sv
hdl/lfu_replacement_lru_tiebreak.sv
bench/lfu_checker.sv
bench/tb_lfu_replacement_lru_tiebreak.sv
